@@ rtl/hngp_pkg.sv @@
// ----------------------------------------------------------------------------
// hngp_pkg
// Shared widths, constants, register codes and mix helpers for the hashed
// noise gradient pixel generator.
// ----------------------------------------------------------------------------
package hngp_pkg;

  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int BATCH_W    = 10;
  localparam int SEED_W     = 32;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_DIM    = 4096;
  localparam int MAX_BATCH  = 1024;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

  // avalanche mix multipliers and coordinate scramble factors
  localparam logic [SEED_W-1:0] MIX_K1  = 32'h7feb352d;
  localparam logic [SEED_W-1:0] MIX_K2  = 32'h846ca68b;
  localparam logic [SEED_W-1:0] HASH_PX = 32'd73856093;
  localparam logic [SEED_W-1:0] HASH_PY = 32'd19349663;

  // gradient divider: 255*coord fits 20 bits, quotient below 256
  localparam int DIVIDEND_W = COORD_W + 8;
  localparam int REM_W      = DIVIDEND_W + 1;
  localparam int DIVQ_W     = PIX_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DIVQ_W / DIV_STEPS;

  // hash pipeline depth, matches DIV_STAGES
  localparam int HASH_LAT   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SEED   = 2'd2
  } cfg_idx_t;

  function automatic logic [SEED_W-1:0] mix_xs16(input logic [SEED_W-1:0] v);
    return v ^ (v >> 16);
  endfunction

  function automatic logic [SEED_W-1:0] mix_xs15(input logic [SEED_W-1:0] v);
    return v ^ (v >> 15);
  endfunction

endpackage

@@ rtl/hashed_noise_gradient_pixel_gen_unit.sv @@
// ----------------------------------------------------------------------------
// hashed_noise_gradient_pixel_gen_unit
// Test-pattern pixel generator: hashed noise over a horizontal/vertical
// color gradient, one RGB pixel per coordinate word.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  input     | start / busy       | in_pixel_x, in_pixel_y, in_batch_index
//  result    | out_valid (strobe) | out_red, out_green, out_blue, out_coord_error
//  config    | cfg_we             | cfg_index, cfg_data
//
//  One word accepted per clock; busy is always low.
//  The pipeline has four stages of hash multiplies / divider bit pairs,
//  then the output register that adds the channel bytes.
//  Reset clears the valid pipeline and loads the default width, height, seed.
//  The result side has no back-pressure, so the pipeline never holds.
// ----------------------------------------------------------------------------
module hashed_noise_gradient_pixel_gen_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hngp_pkg::COORD_W-1:0]    in_pixel_x,
  input  logic [hngp_pkg::COORD_W-1:0]    in_pixel_y,
  input  logic [hngp_pkg::BATCH_W-1:0]    in_batch_index,
  output logic                            out_valid,
  output logic [hngp_pkg::PIX_W-1:0]      out_red,
  output logic [hngp_pkg::PIX_W-1:0]      out_green,
  output logic [hngp_pkg::PIX_W-1:0]      out_blue,
  output logic                            out_coord_error,
  input  logic                            cfg_we,
  input  logic [hngp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hngp_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [hngp_pkg::DIM_W-1:0]  cfg_width_r, cfg_height_r;
  logic [hngp_pkg::SEED_W-1:0] cfg_seed_r;

  logic                            accept;
  logic [hngp_pkg::DIM_W-1:0]      width_eff, height_eff;
  logic                            err_in;
  logic [hngp_pkg::DIVIDEND_W-1:0] dvd_x, dvd_y;
  logic [hngp_pkg::HASH_LAT-1:0]   err_r;

  logic                          hsh_vld, divx_vld, divy_vld;
  logic [hngp_pkg::SEED_W-1:0]   base_w, noise_w;
  logic [hngp_pkg::DIVQ_W-1:0]   gx_w, gy_w;

  logic                          out_valid_r;
  logic                          out_err_r, out_err_nxt;
  logic [hngp_pkg::PIX_W-1:0]    red_r, red_nxt;
  logic [hngp_pkg::PIX_W-1:0]    green_r, green_nxt;
  logic [hngp_pkg::PIX_W-1:0]    blue_r, blue_nxt;

  // ---- configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= hngp_pkg::DIM_RESET;
      cfg_height_r <= hngp_pkg::DIM_RESET;
      cfg_seed_r   <= '0;
    end else if (cfg_we) begin
      unique case (hngp_pkg::cfg_idx_t'(cfg_index))
        hngp_pkg::CFG_WIDTH:  cfg_width_r  <= cfg_data[hngp_pkg::DIM_W-1:0];
        hngp_pkg::CFG_HEIGHT: cfg_height_r <= cfg_data[hngp_pkg::DIM_W-1:0];
        hngp_pkg::CFG_SEED:   cfg_seed_r   <= cfg_data[hngp_pkg::SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- front end: range check and gradient dividends
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    width_eff  = (cfg_width_r > hngp_pkg::DIM_W'(hngp_pkg::MAX_DIM))
                 ? hngp_pkg::DIM_W'(hngp_pkg::MAX_DIM) : cfg_width_r;
    height_eff = (cfg_height_r > hngp_pkg::DIM_W'(hngp_pkg::MAX_DIM))
                 ? hngp_pkg::DIM_W'(hngp_pkg::MAX_DIM) : cfg_height_r;
    err_in = (hngp_pkg::DIM_W'(in_pixel_x) >= width_eff)
          || (hngp_pkg::DIM_W'(in_pixel_y) >= height_eff)
          || ((hngp_pkg::BATCH_W+1)'(in_batch_index)
              >= (hngp_pkg::BATCH_W+1)'(hngp_pkg::MAX_BATCH));
    // 255*c as (c << 8) - c
    dvd_x = (hngp_pkg::DIVIDEND_W'(in_pixel_x) << 8) - hngp_pkg::DIVIDEND_W'(in_pixel_x);
    dvd_y = (hngp_pkg::DIVIDEND_W'(in_pixel_y) << 8) - hngp_pkg::DIVIDEND_W'(in_pixel_y);
  end

  always_ff @(posedge clk) begin
    err_r <= {err_r[hngp_pkg::HASH_LAT-2:0], err_in};
  end

  hngp_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_seed   (cfg_seed_r),
    .in_batch  (in_batch_index),
    .in_px     (in_pixel_x),
    .in_py     (in_pixel_y),
    .out_valid (hsh_vld),
    .out_base  (base_w),
    .out_noise (noise_w)
  );

  hngp_grad_div u_div_x (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (accept),
    .in_dividend (dvd_x),
    .in_divisor  (width_eff),
    .out_valid   (divx_vld),
    .out_quot    (gx_w)
  );

  hngp_grad_div u_div_y (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (accept),
    .in_dividend (dvd_y),
    .in_divisor  (height_eff),
    .out_valid   (divy_vld),
    .out_quot    (gy_w)
  );

  // ---- output stage: byte sums mod 256, zeroed on a coordinate error
  always_comb begin
    out_err_nxt = err_r[hngp_pkg::HASH_LAT-1];
    red_nxt   = gx_w + hngp_pkg::PIX_W'(noise_w[5:0]) + hngp_pkg::PIX_W'(base_w[6:0]);
    green_nxt = gy_w + hngp_pkg::PIX_W'(noise_w[13:8]) + hngp_pkg::PIX_W'(base_w[14:8]);
    blue_nxt  = (gx_w >> 1) + (gy_w >> 1)
              + hngp_pkg::PIX_W'(noise_w[22:16]) + hngp_pkg::PIX_W'(base_w[21:16]);
    if (out_err_nxt) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hsh_vld;
    end
    out_err_r <= out_err_nxt;
    red_r     <= red_nxt;
    green_r   <= green_nxt;
    blue_r    <= blue_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_coord_error = out_err_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;

  // ---- assertions
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (hsh_vld == divx_vld) && (hsh_vld == divy_vld))
    else $error("hash and divider valid bits out of step");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("accepted word did not produce a result after 5 cycles");

  a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hsh_vld && !err_r[hngp_pkg::HASH_LAT-1])
      |-> (gx_w != 8'hff) && (gy_w != 8'hff))
    else $error("gradient quotient out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coord_error)
      |-> (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("error word carries nonzero pixel");

endmodule

@@ rtl/hngp_grad_div.sv @@
// ----------------------------------------------------------------------------
// hngp_grad_div
// Pipelined restoring divider for the gradient: quotient of a 20-bit
// dividend by the image dimension, two quotient bits per stage.
// ----------------------------------------------------------------------------
module hngp_grad_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [hngp_pkg::DIVIDEND_W-1:0] in_dividend,
  input  logic [hngp_pkg::DIM_W-1:0]      in_divisor,
  output logic                            out_valid,
  output logic [hngp_pkg::DIVQ_W-1:0]     out_quot
);

  logic [hngp_pkg::DIV_STAGES-1:0] vld_r;
  logic [hngp_pkg::REM_W-1:0]      rem_r  [hngp_pkg::DIV_STAGES];
  logic [hngp_pkg::DIVQ_W-1:0]     quot_r [hngp_pkg::DIV_STAGES];
  logic [hngp_pkg::DIM_W-1:0]      dvs_r  [hngp_pkg::DIV_STAGES];

  for (genvar s = 0; s < hngp_pkg::DIV_STAGES; s++) begin : g_stage
    logic                        vld_in;
    logic [hngp_pkg::REM_W-1:0]  rem_in;
    logic [hngp_pkg::DIVQ_W-1:0] quot_in;
    logic [hngp_pkg::DIM_W-1:0]  dvs_in;
    logic [hngp_pkg::REM_W-1:0]  rem_nxt;
    logic [hngp_pkg::DIVQ_W-1:0] quot_nxt;

    if (s == 0) begin : g_head
      assign vld_in  = in_valid;
      assign rem_in  = hngp_pkg::REM_W'(in_dividend);
      assign quot_in = '0;
      assign dvs_in  = in_divisor;
    end else begin : g_body
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign quot_in = quot_r[s-1];
      assign dvs_in  = dvs_r[s-1];
    end

    // quotient bits taken MSB first; valid only while dividend < 256*divisor
    always_comb begin
      logic [hngp_pkg::REM_W-1:0] sub;
      rem_nxt  = rem_in;
      quot_nxt = quot_in;
      for (int j = 0; j < hngp_pkg::DIV_STEPS; j++) begin
        sub = hngp_pkg::REM_W'(dvs_in)
              << (hngp_pkg::DIVQ_W - 1 - s * hngp_pkg::DIV_STEPS - j);
        if (rem_nxt >= sub) begin
          rem_nxt = rem_nxt - sub;
          quot_nxt[hngp_pkg::DIVQ_W-1-s*hngp_pkg::DIV_STEPS-j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
      rem_r[s]  <= rem_nxt;
      quot_r[s] <= quot_nxt;
      dvs_r[s]  <= dvs_in;
    end
  end

  assign out_valid = vld_r[hngp_pkg::DIV_STAGES-1];
  assign out_quot  = quot_r[hngp_pkg::DIV_STAGES-1];

endmodule

@@ rtl/hngp_hash.sv @@
// ----------------------------------------------------------------------------
// hngp_hash
// Four-stage hash pipeline: per-image base word and per-pixel noise word,
// one 32x32 multiply per stage, plus the two coordinate scrambles in stage 1.
// ----------------------------------------------------------------------------
module hngp_hash (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [hngp_pkg::SEED_W-1:0]  in_seed,
  input  logic [hngp_pkg::BATCH_W-1:0] in_batch,
  input  logic [hngp_pkg::COORD_W-1:0] in_px,
  input  logic [hngp_pkg::COORD_W-1:0] in_py,
  output logic                         out_valid,
  output logic [hngp_pkg::SEED_W-1:0]  out_base,
  output logic [hngp_pkg::SEED_W-1:0]  out_noise
);

  logic [hngp_pkg::HASH_LAT-1:0] vld_r;

  logic [hngp_pkg::SEED_W-1:0] a1_r, a1_nxt;
  logic [hngp_pkg::SEED_W-1:0] pxm_r, pxm_nxt;
  logic [hngp_pkg::SEED_W-1:0] pym_r, pym_nxt;
  logic [hngp_pkg::SEED_W-1:0] a2_r, a2_nxt;
  logic [hngp_pkg::SEED_W-1:0] crd_r, crd_nxt;
  logic [hngp_pkg::SEED_W-1:0] base3_r, base3_nxt;
  logic [hngp_pkg::SEED_W-1:0] n1_r, n1_nxt;
  logic [hngp_pkg::SEED_W-1:0] base4_r;
  logic [hngp_pkg::SEED_W-1:0] n2_r, n2_nxt;

  always_comb begin
    // stage 1: first base multiply, coordinate scrambles in parallel
    a1_nxt  = hngp_pkg::mix_xs16(in_seed ^ hngp_pkg::SEED_W'(in_batch)) * hngp_pkg::MIX_K1;
    pxm_nxt = hngp_pkg::SEED_W'(in_px) * hngp_pkg::HASH_PX;
    pym_nxt = hngp_pkg::SEED_W'(in_py) * hngp_pkg::HASH_PY;
    // stage 2: second base multiply, scrambled coordinates combined
    a2_nxt  = hngp_pkg::mix_xs15(a1_r) * hngp_pkg::MIX_K2;
    crd_nxt = pxm_r ^ pym_r;
    // stage 3: base done, first noise multiply
    base3_nxt = hngp_pkg::mix_xs16(a2_r);
    n1_nxt    = hngp_pkg::mix_xs16(base3_nxt ^ crd_r) * hngp_pkg::MIX_K1;
    // stage 4: second noise multiply
    n2_nxt    = hngp_pkg::mix_xs15(n1_r) * hngp_pkg::MIX_K2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[hngp_pkg::HASH_LAT-2:0], in_valid};
    end
    a1_r    <= a1_nxt;
    pxm_r   <= pxm_nxt;
    pym_r   <= pym_nxt;
    a2_r    <= a2_nxt;
    crd_r   <= crd_nxt;
    base3_r <= base3_nxt;
    n1_r    <= n1_nxt;
    base4_r <= base3_r;
    n2_r    <= n2_nxt;
  end

  assign out_valid = vld_r[hngp_pkg::HASH_LAT-1];
  assign out_base  = base4_r;
  assign out_noise = hngp_pkg::mix_xs16(n2_r);

endmodule
